FILE: hw/rtl/assert_macros.svh
// Assertion macros shared by the checker files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked property, disabled while reset is asserted.
`define ASSERT_CLK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Same-cycle implication.
`define ASSERT_IMPL(lbl, ante, cons, msg) \
  `ASSERT_CLK(lbl, (ante) |-> (cons), msg)

// Next-cycle implication.
`define ASSERT_NEXT(lbl, ante, cons, msg) \
  `ASSERT_CLK(lbl, (ante) |=> (cons), msg)

`endif

FILE: hw/rtl/drp_pkg.sv
// Types, option codes and helpers shared by the DHCP reply parser modules.
package drp_pkg;

  // Option walker phase
  typedef enum logic [1:0] {
    PH_TYPE  = 2'd0,
    PH_LEN   = 2'd1,
    PH_VALUE = 2'd2
  } phase_e;

  // Per-packet verdict codes
  typedef enum logic [1:0] {
    VERDICT_ERROR = 2'd0,
    VERDICT_ACK   = 2'd1,
    VERDICT_OFFER = 2'd2,
    VERDICT_OTHER = 2'd3
  } verdict_e;

  // DHCP option types
  localparam logic [7:0] OPT_PAD       = 8'd0;
  localparam logic [7:0] OPT_SUBNET    = 8'd1;
  localparam logic [7:0] OPT_ROUTER    = 8'd3;
  localparam logic [7:0] OPT_LEASE     = 8'd51;
  localparam logic [7:0] OPT_MSG_TYPE  = 8'd53;
  localparam logic [7:0] OPT_SERVER_ID = 8'd54;
  localparam logic [7:0] OPT_END       = 8'd255;

  // DHCP message types
  localparam logic [7:0] MSG_OFFER = 8'd2;
  localparam logic [7:0] MSG_ACK   = 8'd5;

  // Found-flag bit positions
  localparam logic [2:0] FLAG_MSG    = 3'd0;
  localparam logic [2:0] FLAG_SUBNET = 3'd1;
  localparam logic [2:0] FLAG_ROUTER = 3'd2;
  localparam logic [2:0] FLAG_SERVER = 3'd3;
  localparam logic [2:0] FLAG_LEASE  = 3'd4;

  // Value slots
  localparam logic [1:0] SLOT_SUBNET = 2'd0;
  localparam logic [1:0] SLOT_ROUTER = 2'd1;
  localparam logic [1:0] SLOT_SERVER = 2'd2;
  localparam logic [1:0] SLOT_LEASE  = 2'd3;

  // Value bytes kept per option; the byte index saturates here
  localparam logic [2:0] VALUE_BYTES = 3'd4;

  // Decode of a wanted option type
  typedef struct packed {
    logic       hit;
    logic       is_kind;
    logic [2:0] flag;
    logic [1:0] slot;
  } opt_sel_t;

  // Beat control from the input stage
  typedef struct packed {
    logic take;
    logic last;
  } beat_ctl_t;

  // Packet summary after the current beat
  typedef struct packed {
    logic        id_match;
    logic [4:0]  found;
    logic [7:0]  kind;
    logic [31:0] yaddr;
    logic [31:0] mask;
    logic [31:0] router;
    logic [31:0] server;
    logic [31:0] lease;
  } pkt_sum_t;

  function automatic opt_sel_t opt_select(logic [7:0] opt_type);
    opt_sel_t sel;
    sel = '0;
    case (opt_type)
      OPT_MSG_TYPE: begin
        sel.hit     = 1'b1;
        sel.is_kind = 1'b1;
        sel.flag    = FLAG_MSG;
      end
      OPT_SUBNET: begin
        sel.hit  = 1'b1;
        sel.flag = FLAG_SUBNET;
        sel.slot = SLOT_SUBNET;
      end
      OPT_ROUTER: begin
        sel.hit  = 1'b1;
        sel.flag = FLAG_ROUTER;
        sel.slot = SLOT_ROUTER;
      end
      OPT_SERVER_ID: begin
        sel.hit  = 1'b1;
        sel.flag = FLAG_SERVER;
        sel.slot = SLOT_SERVER;
      end
      OPT_LEASE: begin
        sel.hit  = 1'b1;
        sel.flag = FLAG_LEASE;
        sel.slot = SLOT_LEASE;
      end
      default: sel = '0;
    endcase
    return sel;
  endfunction

endpackage

FILE: hw/rtl/drp_walker.sv
// Per-byte header check, yiaddr capture and option TLV walker with its state.
module drp_walker import drp_pkg::*; #(
  parameter int unsigned PACKET_BYTES_MAX = 1024
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  beat_ctl_t   ctl_i,
  input  logic [7:0]  byte_i,
  input  logic [31:0] tid_i,
  output pkt_sum_t    sum_o
);

  localparam int unsigned OffW = $clog2(PACKET_BYTES_MAX + 1);
  localparam logic [OffW-1:0] OffLimit = OffW'(PACKET_BYTES_MAX);
  localparam logic [OffW-1:0] IdFirst  = OffW'(4);
  localparam logic [OffW-1:0] IdLast   = OffW'(7);
  localparam logic [OffW-1:0] YaFirst  = OffW'(16);
  localparam logic [OffW-1:0] YaLast   = OffW'(19);
  localparam logic [OffW-1:0] OptStart = OffW'(240);

  logic [OffW-1:0] off_q, off_d;
  phase_e          phase_q, phase_d;
  logic [7:0]      type_q, type_d;
  logic [7:0]      remain_q, remain_d;
  logic [2:0]      vidx_q, vidx_d;
  logic            id_match_q, id_match_d;
  logic            end_q, end_d;
  logic [31:0]     yaddr_q, yaddr_d;
  logic [4:0]      found_q, found_d;
  logic [7:0]      kind_q, kind_d;
  logic [31:0]     vals_q [4];
  logic [31:0]     vals_d [4];

  opt_sel_t        sel;
  logic            capture;
  logic [7:0]      tid_byte;

  assign sel     = opt_select(type_q);
  assign capture = sel.hit && !found_q[sel.flag];

  // Expected id byte for this header offset, first wire byte most significant
  always_comb begin
    unique case (off_q[1:0])
      2'd0:    tid_byte = tid_i[31:24];
      2'd1:    tid_byte = tid_i[23:16];
      2'd2:    tid_byte = tid_i[15:8];
      default: tid_byte = tid_i[7:0];
    endcase
  end

  // Next state after this byte
  always_comb begin
    off_d      = off_q;
    phase_d    = phase_q;
    type_d     = type_q;
    remain_d   = remain_q;
    vidx_d     = vidx_q;
    id_match_d = id_match_q;
    end_d      = end_q;
    yaddr_d    = yaddr_q;
    found_d    = found_q;
    kind_d     = kind_q;
    vals_d     = vals_q;

    if (off_q < OffLimit) begin
      if (off_q >= IdFirst && off_q <= IdLast) begin
        if (tid_byte != byte_i) id_match_d = 1'b0;
      end else if (off_q >= YaFirst && off_q <= YaLast) begin
        yaddr_d = {yaddr_q[23:0], byte_i};
      end else if (off_q >= OptStart && !end_q) begin
        unique case (phase_q)
          PH_LEN: begin
            remain_d = byte_i;
            vidx_d   = 3'd0;
            if (capture) begin
              if (sel.is_kind) kind_d = 8'd0;
              else             vals_d[sel.slot] = 32'd0;
            end
            if (byte_i == 8'd0) begin
              if (sel.hit) found_d[sel.flag] = 1'b1;
              phase_d = PH_TYPE;
            end else begin
              phase_d = PH_VALUE;
            end
          end
          PH_VALUE: begin
            if (capture && vidx_q != VALUE_BYTES) begin
              if (sel.is_kind) begin
                if (vidx_q == 3'd0) kind_d = byte_i;
              end else begin
                unique case (vidx_q[1:0])
                  2'd0: vals_d[sel.slot][31:24] = vals_q[sel.slot][31:24] | byte_i;
                  2'd1: vals_d[sel.slot][23:16] = vals_q[sel.slot][23:16] | byte_i;
                  2'd2: vals_d[sel.slot][15:8]  = vals_q[sel.slot][15:8]  | byte_i;
                  default: vals_d[sel.slot][7:0] = vals_q[sel.slot][7:0] | byte_i;
                endcase
              end
            end
            if (vidx_q != VALUE_BYTES) vidx_d = vidx_q + 3'd1;
            remain_d = remain_q - 8'd1;
            if (remain_d == 8'd0) begin
              if (sel.hit) found_d[sel.flag] = 1'b1;
              phase_d = PH_TYPE;
            end
          end
          default: begin
            // pad takes one byte; END stops the walk
            if (byte_i == OPT_END) begin
              end_d = 1'b1;
            end else if (byte_i != OPT_PAD) begin
              type_d  = byte_i;
              phase_d = PH_LEN;
            end
          end
        endcase
      end
      off_d = off_q + 1'b1;
    end
  end

  // Summary seen by the verdict stage
  assign sum_o.id_match = id_match_d;
  assign sum_o.found    = found_d;
  assign sum_o.kind     = kind_d;
  assign sum_o.yaddr    = yaddr_d;
  assign sum_o.mask     = vals_d[SLOT_SUBNET];
  assign sum_o.router   = vals_d[SLOT_ROUTER];
  assign sum_o.server   = vals_d[SLOT_SERVER];
  assign sum_o.lease    = vals_d[SLOT_LEASE];

  // Parser state; cleared after the final byte of each packet
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      off_q      <= '0;
      phase_q    <= PH_TYPE;
      type_q     <= '0;
      remain_q   <= '0;
      vidx_q     <= '0;
      id_match_q <= 1'b1;
      end_q      <= 1'b0;
      yaddr_q    <= '0;
      found_q    <= '0;
      kind_q     <= '0;
      vals_q     <= '{default: '0};
    end else if (ctl_i.take) begin
      if (ctl_i.last) begin
        off_q      <= '0;
        phase_q    <= PH_TYPE;
        type_q     <= '0;
        remain_q   <= '0;
        vidx_q     <= '0;
        id_match_q <= 1'b1;
        end_q      <= 1'b0;
        yaddr_q    <= '0;
        found_q    <= '0;
        kind_q     <= '0;
        vals_q     <= '{default: '0};
      end else begin
        off_q      <= off_d;
        phase_q    <= phase_d;
        type_q     <= type_d;
        remain_q   <= remain_d;
        vidx_q     <= vidx_d;
        id_match_q <= id_match_d;
        end_q      <= end_d;
        yaddr_q    <= yaddr_d;
        found_q    <= found_d;
        kind_q     <= kind_d;
        vals_q     <= vals_d;
      end
    end
  end

endmodule

FILE: hw/rtl/drp_verdict.sv
// Packet verdict, latched lease/offer/ack values and the result register.
module drp_verdict import drp_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  beat_ctl_t   ctl_i,
  input  pkt_sum_t    sum_i,
  input  logic        out_stall_i,
  output logic        out_valid_o,
  output logic [1:0]  verdict_o,
  output logic [31:0] offered_ip_o,
  output logic [31:0] server_ip_o,
  output logic [31:0] lease_seconds_o,
  output logic [31:0] subnet_mask_out_o,
  output logic [31:0] gateway_out_o
);

  verdict_e    verdict_q, verdict_d;
  logic        out_valid_q, out_valid_d;
  logic [31:0] offer_q, server_q, lease_q, mask_q, gateway_q;
  logic        finish;

  assign finish = ctl_i.take && ctl_i.last;

  // Judge the packet as it stands after its final byte
  always_comb begin
    priority if (!sum_i.id_match || !sum_i.found[FLAG_MSG]) begin
      verdict_d = VERDICT_ERROR;
    end else if (sum_i.kind == MSG_ACK) begin
      if (offer_q != sum_i.yaddr || !sum_i.found[FLAG_SUBNET] || !sum_i.found[FLAG_ROUTER])
        verdict_d = VERDICT_ERROR;
      else
        verdict_d = VERDICT_ACK;
    end else if (sum_i.kind == MSG_OFFER) begin
      if (!sum_i.found[FLAG_SERVER] || !sum_i.found[FLAG_LEASE])
        verdict_d = VERDICT_ERROR;
      else
        verdict_d = VERDICT_OFFER;
    end else begin
      verdict_d = VERDICT_OTHER;
    end
  end

  // Result valid: set on a final byte, dropped once taken
  always_comb begin
    out_valid_d = out_valid_q;
    if (finish)            out_valid_d = 1'b1;
    else if (!out_stall_i) out_valid_d = 1'b0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      verdict_q   <= VERDICT_ERROR;
      offer_q     <= '0;
      server_q    <= '0;
      lease_q     <= '0;
      mask_q      <= '0;
      gateway_q   <= '0;
    end else begin
      out_valid_q <= out_valid_d;
      if (finish) begin
        verdict_q <= verdict_d;
        if (verdict_d == VERDICT_ACK) begin
          mask_q    <= sum_i.mask;
          gateway_q <= sum_i.router;
        end
        if (verdict_d == VERDICT_OFFER) begin
          offer_q  <= sum_i.yaddr;
          server_q <= sum_i.server;
          lease_q  <= sum_i.lease;
        end
      end
    end
  end

  // Latched values change only with a new result, so they hold while stalled
  assign out_valid_o       = out_valid_q;
  assign verdict_o         = verdict_q;
  assign offered_ip_o      = offer_q;
  assign server_ip_o       = server_q;
  assign lease_seconds_o   = lease_q;
  assign subnet_mask_out_o = mask_q;
  assign gateway_out_o     = gateway_q;

endmodule

FILE: hw/rtl/dhcp_reply_parser.sv
// Top level of the byte-serial DHCP reply parser.
//
//  channel  | direction | handshake               | payload
//  ---------+-----------+-------------------------+------------------------------------
//  in       | sink      | in_valid_i / in_stall_o | packet_byte_i, last_byte_i
//  out      | source    | out_valid_o/out_stall_i | verdict_o, send_request_o, 5 x 32b
//  cfg      | sink      | cfg_we_i                | cfg_wdata_i (transaction id)
//
// One byte is taken every cycle unless a final byte is stalled; a result passes
// through the input register, then the result register.
// The only stall comes from a final byte that meets a result still held by the
// output side; ordinary bytes flow on regardless.
// Reset clears latched values and the transaction id to zero and returns the parser to its start state.
module dhcp_reply_parser import drp_pkg::*; #(
  parameter int unsigned PACKET_BYTES_MAX = 1024
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [31:0] cfg_wdata_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  packet_byte_i,
  input  logic        last_byte_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [1:0]  verdict_o,
  output logic        send_request_o,
  output logic [31:0] offered_ip_o,
  output logic [31:0] server_ip_o,
  output logic [31:0] lease_seconds_o,
  output logic [31:0] subnet_mask_out_o,
  output logic [31:0] gateway_out_o
);

  logic [31:0] tid_q;
  logic        in_valid_q;
  logic [7:0]  byte_q;
  logic        last_q;
  beat_ctl_t   ctl;
  pkt_sum_t    sum;

  // Transaction id register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tid_q <= '0;
    end else if (cfg_we_i) begin
      tid_q <= cfg_wdata_i;
    end
  end

  // A final byte waits only while the result register is full and stalled
  assign ctl.take   = in_valid_q && (!last_q || !out_valid_o || !out_stall_i);
  assign ctl.last   = last_q;
  assign in_stall_o = in_valid_q && !ctl.take;

  // Input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (!in_stall_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!in_stall_o) begin
      byte_q <= packet_byte_i;
      last_q <= last_byte_i;
    end
  end

  drp_walker #(
    .PACKET_BYTES_MAX(PACKET_BYTES_MAX)
  ) u_walker (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctl_i  (ctl),
    .byte_i (byte_q),
    .tid_i  (tid_q),
    .sum_o  (sum)
  );

  drp_verdict u_verdict (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .ctl_i             (ctl),
    .sum_i             (sum),
    .out_stall_i       (out_stall_i),
    .out_valid_o       (out_valid_o),
    .verdict_o         (verdict_o),
    .offered_ip_o      (offered_ip_o),
    .server_ip_o       (server_ip_o),
    .lease_seconds_o   (lease_seconds_o),
    .subnet_mask_out_o (subnet_mask_out_o),
    .gateway_out_o     (gateway_out_o)
  );

  assign send_request_o = (verdict_o == VERDICT_OFFER);

endmodule

FILE: hw/rtl/drp_checker.sv
// Port-level checker for the DHCP reply parser and its bind.
`include "assert_macros.svh"

module drp_checker import drp_pkg::*; (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input logic [1:0]  verdict_o,
  input logic        send_request_o,
  input logic [31:0] offered_ip_o,
  input logic [31:0] server_ip_o,
  input logic [31:0] lease_seconds_o,
  input logic [31:0] subnet_mask_out_o,
  input logic [31:0] gateway_out_o
);

  // request flag agrees with the verdict
  `ASSERT_IMPL(a_req_is_offer, out_valid_o, send_request_o == (verdict_o == VERDICT_OFFER), "send_request disagrees with verdict")

  // offer values move only with a new accepted offer
  `ASSERT_IMPL(a_offer_latch, !$stable(offered_ip_o) || !$stable(server_ip_o) || !$stable(lease_seconds_o), out_valid_o && verdict_o == VERDICT_OFFER, "offer values changed without an offer")

  // ack values move only with a new accepted ack
  `ASSERT_IMPL(a_ack_latch, !$stable(subnet_mask_out_o) || !$stable(gateway_out_o), out_valid_o && verdict_o == VERDICT_ACK, "ack values changed without an ack")

  // a stalled result stays and holds its verdict
  `ASSERT_NEXT(a_valid_hold, out_valid_o && out_stall_i, out_valid_o, "result dropped while stalled")
  `ASSERT_NEXT(a_verdict_hold, out_valid_o && out_stall_i, $stable(verdict_o), "verdict changed while stalled")

endmodule

bind dhcp_reply_parser drp_checker u_drp_checker (.*);
